/* hw/rtl/lphm_pkg.sv */
// Shared types and constants of the linear probing hash map.
package lphm_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 1024;
  localparam int unsigned KEY_BYTES_DEF   = 8;

  localparam int unsigned KEY_FIELD_W = 64;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned VALUE_W     = 48;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned IN_DATA_W   = 120;

  localparam int unsigned HASH_W = 16;
  localparam logic [HASH_W-1:0] DJB_SEED = 16'd5381;
  localparam int unsigned DJB_SHIFT = 5;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_HIT      = 3'd3,
    STAT_MISS     = 3'd4
  } lphm_status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK
  } lphm_state_e;

endpackage

/* hw/rtl/lphm_ram.sv */
// Slot memory: one write port, one registered read port.
module lphm_ram #(
  parameter int unsigned DEPTH  = lphm_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned WIDTH  = 117,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/lphm_ctrl.sv */
// Request sequencer: hashing, probe loop, clearing sweep and result register.
module lphm_ctrl #(
  parameter int unsigned TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KEY_BYTES   = lphm_pkg::KEY_BYTES_DEF,
  parameter int unsigned IDX_W       = $clog2(TABLE_SLOTS),
  parameter int unsigned KEY_W       = 8 * KEY_BYTES,
  parameter int unsigned ENTRY_W     = 1 + lphm_pkg::LEN_W + KEY_W + lphm_pkg::VALUE_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [lphm_pkg::KEY_FIELD_W-1:0]  key_bytes_i,
  input  logic [lphm_pkg::LEN_W-1:0]        key_length_i,
  input  logic [lphm_pkg::VALUE_W-1:0]      value_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lphm_pkg::STATUS_W-1:0]     status_o,
  output logic [lphm_pkg::VALUE_W-1:0]      value_out_o,
  output logic                              ram_rd_en_o,
  output logic [IDX_W-1:0]                  ram_rd_addr_o,
  input  logic [ENTRY_W-1:0]                ram_rd_data_i,
  output logic                              ram_wr_en_o,
  output logic [IDX_W-1:0]                  ram_wr_addr_o,
  output logic [ENTRY_W-1:0]                ram_wr_data_o
);

  localparam int unsigned LEN_W   = lphm_pkg::LEN_W;
  localparam int unsigned VALUE_W = lphm_pkg::VALUE_W;
  localparam int unsigned HASH_W  = lphm_pkg::HASH_W;

  lphm_pkg::lphm_state_e  state_q, state_d;
  logic [IDX_W-1:0]       clr_q, clr_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W-1:0]       start_q, start_d;
  logic                   out_valid_q, out_valid_d;
  lphm_pkg::lphm_status_e out_status_q, out_status_d;
  logic [VALUE_W-1:0]     out_value_q, out_value_d;
  logic [HASH_W-1:0]      hash_q, hash_d;
  logic [LEN_W-1:0]       hcnt_q, hcnt_d;

  logic                   mode_q;
  logic [KEY_W-1:0]       key_q;
  logic [LEN_W-1:0]       len_q;
  logic [VALUE_W-1:0]     value_q;

  logic                   accept;
  logic [LEN_W-1:0]       len_sat;
  logic [KEY_W-1:0]       key_masked;

  logic                   e_used;
  logic [LEN_W-1:0]       e_len;
  logic [KEY_W-1:0]       e_key;
  logic [VALUE_W-1:0]     e_value;
  logic                   match;
  logic                   out_free;
  logic [IDX_W-1:0]       next_idx;
  logic                   lap_done;

  assign in_ready_o = (state_q == lphm_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign len_sat = (key_length_i > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_length_i;

  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_masked[8*b +: 8] = (LEN_W'(b) < len_sat) ? key_bytes_i[8*b +: 8] : 8'd0;
    end
  end

  assign e_used   = ram_rd_data_i[ENTRY_W-1];
  assign e_len    = ram_rd_data_i[ENTRY_W-2 -: LEN_W];
  assign e_key    = ram_rd_data_i[VALUE_W +: KEY_W];
  assign e_value  = ram_rd_data_i[VALUE_W-1:0];
  assign match    = e_used && (e_len == len_q) && (e_key == key_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign next_idx = idx_q + IDX_W'(1);
  assign lap_done = (next_idx == start_q);

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    idx_d         = idx_q;
    start_d       = start_q;
    hash_d        = hash_q;
    hcnt_d        = hcnt_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_status_d  = out_status_q;
    out_value_d   = out_value_q;
    ram_rd_en_o   = 1'b0;
    ram_rd_addr_o = idx_q;
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = idx_q;
    ram_wr_data_o = {1'b1, len_q, key_q, value_q};
    unique case (state_q)
      lphm_pkg::ST_CLEAR: begin
        ram_wr_en_o   = 1'b1;
        ram_wr_addr_o = clr_q;
        ram_wr_data_o = '0;
        clr_d         = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(TABLE_SLOTS - 1)) begin
          state_d = lphm_pkg::ST_IDLE;
        end
      end
      lphm_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lphm_pkg::ST_HASH;
          hash_d  = lphm_pkg::DJB_SEED;
          hcnt_d  = '0;
        end
      end
      lphm_pkg::ST_HASH: begin
        // fold one key byte per cycle into the low hash bits
        if (hcnt_q < len_q) begin
          hash_d = (hash_q << lphm_pkg::DJB_SHIFT) + hash_q + HASH_W'(key_q[8*hcnt_q +: 8]);
          hcnt_d = hcnt_q + LEN_W'(1);
        end else begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = hash_q[IDX_W-1:0];
          idx_d         = hash_q[IDX_W-1:0];
          start_d       = hash_q[IDX_W-1:0];
          state_d       = lphm_pkg::ST_CHECK;
        end
      end
      lphm_pkg::ST_CHECK: begin
        if (!e_used || match || lap_done) begin
          // hold the read data until the result register is free
          if (out_free) begin
            out_valid_d = 1'b1;
            out_value_d = '0;
            state_d     = lphm_pkg::ST_IDLE;
            if (!e_used) begin
              out_status_d = mode_q ? lphm_pkg::STAT_MISS : lphm_pkg::STAT_INSERTED;
              ram_wr_en_o  = !mode_q;
            end else if (match) begin
              out_status_d = mode_q ? lphm_pkg::STAT_HIT : lphm_pkg::STAT_UPDATED;
              out_value_d  = mode_q ? e_value : '0;
              ram_wr_en_o  = !mode_q;
            end else begin
              out_status_d = mode_q ? lphm_pkg::STAT_MISS : lphm_pkg::STAT_FULL;
            end
          end
        end else begin
          ram_rd_en_o   = 1'b1;
          ram_rd_addr_o = next_idx;
          idx_d         = next_idx;
        end
      end
      default: begin
        state_d = lphm_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lphm_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    start_q      <= start_d;
    hash_q       <= hash_d;
    hcnt_q       <= hcnt_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    if (accept) begin
      mode_q  <= mode_i;
      key_q   <= key_masked;
      len_q   <= len_sat;
      value_q <= value_in_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign value_out_o = out_value_q;

endmodule

/* hw/rtl/linear_probe_hash_map.sv */
// Top level of the linear probing hash map.
//
// Requests enter on the s_axis channel: tuser is the mode (0 put, 1 get),
// tdata carries key bytes, key length and the value to store. Each request
// gives exactly one result on the m_axis channel: tuser is the status
// (inserted, updated, table full, hit, miss), tdata the stored value on a hit.
// The start slot is the low IDX_W bits of the 16-bit DJB2 hash of the key;
// probing is linear with wrap-around through one slot memory.
// After acceptance the block folds the key into the hash, one key byte per
// cycle over the saturated key length (0 to KEY_BYTES), then issues the first
// read and probes up to TABLE_SLOTS slots in turn on the single read port of
// the slot memory; it takes the next request only once it is idle again.
// After reset the block sweeps the slot memory, one slot per cycle, and holds
// s_axis_tready low until the sweep ends.
// A finished result waits in an output register; while the receiver stalls,
// the next request is still taken and its probes run; it holds only when its
// own result is ready and the register is still occupied.
module linear_probe_hash_map #(
  parameter int unsigned TABLE_SLOTS = lphm_pkg::TABLE_SLOTS_DEF,
  parameter int unsigned KEY_BYTES   = lphm_pkg::KEY_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // key_bytes [63:0], key_length [67:64], value_in [115:68], zero [119:116]
  input  logic [lphm_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // mode [0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // value_out [47:0]
  output logic [lphm_pkg::VALUE_W-1:0]        m_axis_tdata,
  // status [2:0]
  output logic [lphm_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
  localparam int unsigned KEY_W   = 8 * KEY_BYTES;
  localparam int unsigned ENTRY_W = 1 + lphm_pkg::LEN_W + KEY_W + lphm_pkg::VALUE_W;
  localparam int unsigned KF_W    = lphm_pkg::KEY_FIELD_W;
  localparam int unsigned LEN_W   = lphm_pkg::LEN_W;
  localparam int unsigned VALUE_W = lphm_pkg::VALUE_W;

  logic               ram_rd_en;
  logic [IDX_W-1:0]   ram_rd_addr;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               ram_wr_en;
  logic [IDX_W-1:0]   ram_wr_addr;
  logic [ENTRY_W-1:0] ram_wr_data;

  lphm_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .IDX_W       (IDX_W),
    .KEY_W       (KEY_W),
    .ENTRY_W     (ENTRY_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .mode_i        (s_axis_tuser),
    .key_bytes_i   (s_axis_tdata[KF_W-1:0]),
    .key_length_i  (s_axis_tdata[KF_W +: LEN_W]),
    .value_in_i    (s_axis_tdata[KF_W + LEN_W +: VALUE_W]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .status_o      (m_axis_tuser),
    .value_out_o   (m_axis_tdata),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  lphm_ram #(
    .DEPTH  (TABLE_SLOTS),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data)
  );

endmodule

/* sim/tb.sv */
// Self-checking testbench for the linear probing hash map.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_SLOTS     = lphm_pkg::TABLE_SLOTS_DEF;
  localparam int unsigned KEY_BYTES       = lphm_pkg::KEY_BYTES_DEF;
  localparam int unsigned KEY_FIELD_W     = lphm_pkg::KEY_FIELD_W;
  localparam int unsigned LEN_W           = lphm_pkg::LEN_W;
  localparam int unsigned VALUE_W         = lphm_pkg::VALUE_W;
  localparam int unsigned STATUS_W        = lphm_pkg::STATUS_W;
  localparam int unsigned IN_DATA_W       = lphm_pkg::IN_DATA_W;
  localparam int unsigned KNOWN_KEY_LIMIT = 350;
  localparam int unsigned LIMIT_CYCLES    = 10_000_000;

  typedef enum bit {
    MODE_PUT = 1'b0,
    MODE_GET = 1'b1
  } mode_e;

  typedef struct {
    lphm_pkg::lphm_status_e status;
    logic [VALUE_W-1:0]     stored_value;
  } lookup_result_t;

  typedef struct {
    logic [KEY_FIELD_W-1:0] key;
    logic [LEN_W-1:0]       len;
  } known_key_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [VALUE_W-1:0]     m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  bit                     slot_used [TABLE_SLOTS];
  logic [KEY_FIELD_W-1:0] slot_key [TABLE_SLOTS];
  logic [LEN_W-1:0]       slot_len [TABLE_SLOTS];
  logic [VALUE_W-1:0]     slot_value [TABLE_SLOTS];

  lookup_result_t         pending_results [$];
  known_key_t             known_keys [$];
  int unsigned            mismatches = 0;
  int unsigned            cycle_count = 0;
  bit                     tx_gaps = 1'b1;
  bit                     rx_gaps = 1'b1;
  int unsigned            rx_hold_len = 0;
  int unsigned            hold_requests = 0;
  int unsigned            hold_seen = 0;
  int unsigned            hold_left = 0;

  linear_probe_hash_map DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen     <= hold_requests;
      hold_left     <= rx_hold_len;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_gaps && $urandom_range(99) < 31);
    end
  end

  always @(posedge clk_i) begin : check_results
    lookup_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d, value_out %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata !== want.stored_value) begin
          $error("value_out: expected %h, got %h", want.stored_value, m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [KEY_FIELD_W-1:0] key_mask(int unsigned len);
    if (len >= KEY_BYTES) return '1;
    return (64'd1 << (8 * len)) - 64'd1;
  endfunction

  function automatic int unsigned home_slot(logic [KEY_FIELD_W-1:0] key, int unsigned len);
    logic [63:0] h;
    h = 64'(lphm_pkg::DJB_SEED);
    for (int i = 0; i < len; i++) h = (h << lphm_pkg::DJB_SHIFT) + h + 64'(key[8*i +: 8]);
    return int'(h % TABLE_SLOTS);
  endfunction

  // Probe the table copy as the block does and update it; returns the result.
  function automatic lookup_result_t apply_request(mode_e mode, logic [KEY_FIELD_W-1:0] raw_key,
                                                   logic [LEN_W-1:0] raw_len,
                                                   logic [VALUE_W-1:0] val);
    lookup_result_t res;
    int unsigned    len;
    int unsigned    first;
    int unsigned    slot;
    logic [KEY_FIELD_W-1:0] key;
    len = (raw_len > KEY_BYTES) ? KEY_BYTES : raw_len;
    key = raw_key & key_mask(len);
    first = home_slot(key, len);
    slot = first;
    res.status = (mode == MODE_GET) ? lphm_pkg::STAT_MISS : lphm_pkg::STAT_FULL;
    res.stored_value = '0;
    do begin
      if (!slot_used[slot]) begin
        if (mode == MODE_PUT) begin
          slot_used[slot]  = 1'b1;
          slot_key[slot]   = key;
          slot_len[slot]   = LEN_W'(len);
          slot_value[slot] = val;
          res.status       = lphm_pkg::STAT_INSERTED;
        end
        break;
      end
      if (slot_len[slot] == len && slot_key[slot] == key) begin
        if (mode == MODE_GET) begin
          res.status       = lphm_pkg::STAT_HIT;
          res.stored_value = slot_value[slot];
        end else begin
          slot_value[slot] = val;
          res.status       = lphm_pkg::STAT_UPDATED;
        end
        break;
      end
      slot = (slot + 1) % TABLE_SLOTS;
    end while (slot != first);
    return res;
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] random_key_bytes();
    logic [KEY_FIELD_W-1:0] k;
    k = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) if ($urandom_range(4) == 0) k[8*i +: 8] = 8'h00;
    return k;
  endfunction

  function automatic logic [LEN_W-1:0] random_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 85) return LEN_W'($urandom_range(KEY_BYTES, 1));
    return LEN_W'($urandom_range(15, KEY_BYTES + 1));
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v[VALUE_W-1:0];
  endfunction

  function automatic logic [KEY_FIELD_W-1:0] find_key_at(int unsigned slot, int unsigned len,
                                                         logic [KEY_FIELD_W-1:0] avoid);
    logic [KEY_FIELD_W-1:0] k;
    do k = random_key_bytes() & key_mask(len);
    while (home_slot(k, len) != slot || k == avoid);
    return k;
  endfunction

  task automatic send_request(mode_e mode, logic [KEY_FIELD_W-1:0] key, logic [LEN_W-1:0] len,
                              logic [VALUE_W-1:0] val);
    if (tx_gaps)
      while ($urandom_range(99) < 31) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, val, len, key};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(mode, key, len, val));
  endtask

  task automatic send_known_key(mode_e mode);
    known_key_t       k;
    logic [63:0]      junk;
    logic [LEN_W-1:0] len;
    k = known_keys[$urandom_range(known_keys.size() - 1)];
    junk = {$urandom, $urandom};
    len = k.len;
    if (len == KEY_BYTES && $urandom_range(3) == 0) len = LEN_W'($urandom_range(15, KEY_BYTES));
    send_request(mode, k.key | (junk & ~key_mask(k.len)), len, random_value());
  endtask

  task automatic send_fresh_key(mode_e mode);
    logic [KEY_FIELD_W-1:0] key;
    logic [LEN_W-1:0]       len;
    int unsigned            eff_len;
    known_key_t             kk;
    key = random_key_bytes();
    len = random_length();
    eff_len = (len > KEY_BYTES) ? KEY_BYTES : len;
    kk.key = key & key_mask(eff_len);
    kk.len = LEN_W'(eff_len);
    if (mode == MODE_PUT) known_keys.push_back(kk);
    send_request(mode, key, len, random_value());
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_basic_keys();
    send_request(MODE_PUT, 64'h0, 4'd0, 48'h1234);
    send_request(MODE_GET, '1, 4'd0, '0);
    send_request(MODE_PUT, '1, 4'd0, '1);
    send_request(MODE_GET, 64'h0, 4'd0, '1);
    send_request(MODE_PUT, '1, 4'd8, '1);
    send_request(MODE_GET, '1, 4'd15, '0);
    send_request(MODE_GET, '1, 4'd9, '0);
    send_request(MODE_PUT, 64'h0, 4'd4, '0);
    send_request(MODE_PUT, 64'hFFFF_FFFF_FF00_0000, 4'd3, 48'hABC);
    send_request(MODE_GET, 64'h0, 4'd4, '0);
    send_request(MODE_GET, 64'h0, 4'd3, '0);
    send_request(MODE_GET, 64'h0, 4'd2, '0);
    send_request(MODE_GET, 64'h41, 4'd1, '0);
    send_request(MODE_PUT, 64'h41, 4'd1, 48'h5555_5555_5555);
    send_request(MODE_GET, 64'hAAAA_AAAA_AAAA_AA41, 4'd1, '0);
  endtask

  task automatic test_collisions();
    logic [KEY_FIELD_W-1:0] first_key;
    logic [KEY_FIELD_W-1:0] second_key;
    first_key  = random_key_bytes() & key_mask(4);
    second_key = find_key_at(home_slot(first_key, 4), 4, first_key);
    send_request(MODE_PUT, first_key, 4'd4, random_value());
    send_request(MODE_PUT, second_key, 4'd4, random_value());
    send_request(MODE_GET, second_key, 4'd4, '0);
    send_request(MODE_GET, first_key, 4'd4, '0);
    send_request(MODE_PUT, second_key, 4'd4, random_value());
    send_request(MODE_GET, second_key, 4'd4, '0);
    first_key  = find_key_at(TABLE_SLOTS - 1, 3, '1);
    second_key = find_key_at(TABLE_SLOTS - 1, 3, first_key);
    send_request(MODE_PUT, first_key, 4'd3, random_value());
    send_request(MODE_PUT, second_key, 4'd3, random_value());
    send_request(MODE_GET, second_key, 4'd3, '0);
  endtask

  task automatic test_random_traffic(int unsigned count);
    mode_e mode;
    for (int i = 0; i < count; i++) begin
      tx_gaps = (i < 700 || i >= 1000);
      rx_gaps = tx_gaps;
      mode = mode_e'($urandom_range(1));
      if (known_keys.size() != 0 && $urandom_range(99) < 55) send_known_key(mode);
      else if (known_keys.size() >= KNOWN_KEY_LIMIT) send_fresh_key(MODE_GET);
      else send_fresh_key(mode);
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold_len = 400;
    hold_requests++;
    repeat (40) send_known_key(mode_e'($urandom_range(1)));
    wait_for_results();
    tx_gaps = 1'b1;
  endtask

  task automatic test_full_table();
    int unsigned len;
    for (int unsigned slot = 0; slot < TABLE_SLOTS; slot++)
      if (!slot_used[slot]) begin
        len = $urandom_range(8, 6);
        send_request(MODE_PUT, find_key_at(slot, len, '1), LEN_W'(len), random_value());
      end
    repeat (6) send_request(MODE_PUT, random_key_bytes(), 4'd8, random_value());
    repeat (6) send_request(MODE_GET, random_key_bytes(), 4'd8, '0);
    repeat (6) send_known_key(MODE_GET);
    repeat (2) send_known_key(MODE_PUT);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_keys();
    wait_for_results();
    test_collisions();
    wait_for_results();
    test_random_traffic(1300);
    wait_for_results();
    test_backpressure();
    test_full_table();
    wait_for_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

/* linear_probe_hash_map.f */
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_ram.sv
hw/rtl/lphm_ctrl.sv
hw/rtl/linear_probe_hash_map.sv
sim/tb.sv
